// ===== rtl/lpl_pkg.sv =====
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared widths, register indexes, reset values and the command and status
// structs that join the limiter controller to its datapath.
// ----------------------------------------------------------------------------
package lpl_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int CV_W       = 16;
   localparam int GAIN_W     = 16;
   localparam int THR_W      = 16;
   localparam int COEF_W     = 16;
   localparam int LOOK_W     = 11;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int T2_W       = THR_W + 3;
   localparam int DIV_STEPS  = 15;
   localparam int DIV_CNT_W  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_LEVEL     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_COEFFICIENT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD_SAMPLES   = CSR_IDX_W'(2);

   localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(31130);
   localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(65508);
   localparam logic [LOOK_W-1:0] LOOK_RESET = LOOK_W'(240);
   localparam logic [GAIN_W-1:0] UNITY      = GAIN_W'(32768);
   localparam logic [THR_W-1:0]  THR_MIN    = THR_W'(3277);

   localparam logic signed [T2_W-1:0] THR2_MIN = T2_W'(6554);
   localparam logic signed [T2_W-1:0] THR2_MAX = T2_W'(65536);

   typedef struct packed {
      logic clear;
      logic accept;
      logic scan;
      logic div_init;
      logic div_step;
      logic gain_mul;
      logic gain_upd;
      logic out_mul;
      logic finish;
   } lpl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic limited;
      logic div_done;
      logic out_free;
   } lpl_status_type;

endpackage

// ===== rtl/lpl_req_if.sv =====
// ----------------------------------------------------------------------------
// lpl_req_if
// Sample channel: one audio sample and one threshold control value a transfer.
// ----------------------------------------------------------------------------
interface lpl_req_if
   import lpl_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] audio_in;
   logic signed [CV_W-1:0]     threshold_cv;

   modport source (output valid, audio_in, threshold_cv, input ready);
   modport sink   (input valid, audio_in, threshold_cv, output ready);
endinterface

// ===== rtl/lpl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lpl_rsp_if
// Result channel: limited sample and gain envelope a transfer.
// ----------------------------------------------------------------------------
interface lpl_rsp_if
   import lpl_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] limited_out;
   logic [GAIN_W-1:0]          gain_now;

   modport source (output valid, limited_out, gain_now, input ready);
   modport sink   (input valid, limited_out, gain_now, output ready);
endinterface

// ===== rtl/lpl_csr_if.sv =====
// ----------------------------------------------------------------------------
// lpl_csr_if
// Register write channel: register index and write data a transfer.
// ----------------------------------------------------------------------------
interface lpl_csr_if
   import lpl_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lpl_ram.sv =====
// ----------------------------------------------------------------------------
// lpl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

// ===== rtl/lpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpl_ctrl
// Sequencer: clear pass, sample transfer, window scan, gain divide,
// envelope update, output multiply and result hand-off.
// ----------------------------------------------------------------------------
module lpl_ctrl
   import lpl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  lpl_status_type status,
   output lpl_cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_SCAN     = 3'd2;
   localparam logic [2:0] ST_DIVIDE   = 3'd3;
   localparam logic [2:0] ST_GAIN_MUL = 3'd4;
   localparam logic [2:0] ST_GAIN_UPD = 3'd5;
   localparam logic [2:0] ST_OUT_MUL  = 3'd6;
   localparam logic [2:0] ST_FINISH   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!status.limited || status.div_done) begin
               state_in = ST_GAIN_MUL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_GAIN_MUL: begin
            cmd.gain_mul = 1'b1;
            state_in     = ST_GAIN_UPD;
         end
         ST_GAIN_UPD: begin
            cmd.gain_upd = 1'b1;
            state_in     = ST_OUT_MUL;
         end
         ST_OUT_MUL: begin
            cmd.out_mul = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_ready)
      else $error("second transfer taken while an item is in flight");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result loaded over an untaken result");
`endif

endmodule

// ===== rtl/lpl_dp.sv =====
// ----------------------------------------------------------------------------
// lpl_dp
// Datapath: registers, delay-line RAM, peak scan, restoring divider,
// envelope and output arithmetic, output register.
// ----------------------------------------------------------------------------
module lpl_dp
   import lpl_pkg::*;
#(
   parameter int DELAY_DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lpl_cmd_type                cmd,
   output lpl_status_type             status,
   input  logic signed [SAMPLE_W-1:0] audio_in,
   input  logic signed [CV_W-1:0]     threshold_cv,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic signed [SAMPLE_W-1:0] limited_out,
   output logic [GAIN_W-1:0]          gain_now
);

   localparam int AW     = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int LW     = $clog2(DELAY_DEPTH + 1);
   localparam int XW     = (LW > LOOK_W) ? LW : LOOK_W;
   localparam int RW     = LW + 1;
   localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
   localparam int RND_W  = PROD_W + 1;

   localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
   localparam logic [XW-1:0] DEPTH_X   = XW'(DELAY_DEPTH);
   localparam logic [RW-1:0] DEPTH_R   = RW'(DELAY_DEPTH);
   localparam logic [LW-1:0] DEPTH_L   = LW'(DELAY_DEPTH);
   localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(1 << (GAIN_W - 2));
   localparam logic signed [RND_W-1:0] SAT_MAX    = RND_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [RND_W-1:0] SAT_MIN    = ~SAT_MAX;

   // registers
   logic [THR_W-1:0]  thr_level_ff;
   logic [COEF_W-1:0] coef_ff;
   logic [LOOK_W-1:0] look_ff;
   logic [AW-1:0]     wp_ff;
   logic [GAIN_W-1:0] env_ff;
   logic              pend_ff;
   logic              rsp_valid_ff;

   logic [THR_W-1:0]           thr_ff;
   logic [AW-1:0]              wcur_ff;
   logic [AW-1:0]              addr_ff;
   logic [LW:0]                left_ff;
   logic                       first_ff;
   logic                       pend_first_ff;
   logic [SAMPLE_W-1:0]        peak_ff;
   logic signed [SAMPLE_W-1:0] delayed_ff;
   logic [THR_W:0]             rem_ff;
   logic [DIV_STEPS-1:0]       quo_ff;
   logic [DIV_CNT_W-1:0]       div_cnt_ff;
   logic                       limited_ff;
   logic [GAIN_W-1:0]          target_ff;
   logic [GAIN_W+COEF_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   outp_ff;
   logic signed [SAMPLE_W-1:0] limited_out_ff;
   logic [GAIN_W-1:0]          gain_now_ff;

   // combinational
   logic signed [T2_W-1:0] t2;
   logic [THR_W-1:0]       thr_c;
   logic [XW-1:0]          look_x;
   logic [LW-1:0]          lsat;
   logic [RW-1:0]          rd_sum;
   logic [AW-1:0]          rd_c;
   logic [AW-1:0]          wp_next;
   logic                   ram_we;
   logic [SAMPLE_W-1:0]    ram_wdata;
   logic                   ram_re;
   logic [SAMPLE_W-1:0]    q_rd;
   logic [SAMPLE_W-1:0]    mag;
   logic [THR_W:0]         rem2;
   logic [GAIN_W-1:0]      target_c;
   logic [GAIN_W-1:0]      diff_c;
   logic signed [RND_W-1:0] rnd;
   logic signed [RND_W-1:0] shifted;
   logic signed [SAMPLE_W-1:0] sat_c;

   always_comb begin
      t2 = $signed({2'b00, thr_level_ff, 1'b0})
           + $signed({{(T2_W - CV_W){threshold_cv[CV_W-1]}}, threshold_cv});
      if (t2 < THR2_MIN) begin
         thr_c = THR_MIN;
      end else if (t2 > THR2_MAX) begin
         thr_c = UNITY;
      end else begin
         thr_c = t2[THR_W:1];
      end

      look_x = XW'(look_ff);
      if (look_ff == '0) begin
         lsat = LW'(1);
      end else if (look_x > DEPTH_X) begin
         lsat = DEPTH_L;
      end else begin
         lsat = LW'(look_x);
      end

      rd_sum = RW'(wp_ff) + DEPTH_R - RW'(lsat);
      if (rd_sum >= DEPTH_R) begin
         rd_c = AW'(rd_sum - DEPTH_R);
      end else begin
         rd_c = AW'(rd_sum);
      end

      wp_next = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;

      mag  = q_rd[SAMPLE_W-1] ? (~q_rd + 1'b1) : q_rd;
      rem2 = {rem_ff[THR_W-1:0], 1'b0};

      target_c = limited_ff ? {1'b0, quo_ff} : UNITY;
      diff_c   = target_c - env_ff;

      rnd     = {outp_ff[PROD_W-1], outp_ff} + ROUND_HALF;
      shifted = rnd >>> (GAIN_W - 1);
      if (shifted > SAT_MAX) begin
         sat_c = SAT_MAX[SAMPLE_W-1:0];
      end else if (shifted < SAT_MIN) begin
         sat_c = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         sat_c = shifted[SAMPLE_W-1:0];
      end
   end

   assign ram_we    = cmd.clear | cmd.accept;
   assign ram_wdata = cmd.clear ? '0 : audio_in;
   assign ram_re    = cmd.scan && (left_ff != '0);

   lpl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DELAY_DEPTH)
   ) u_delay_line (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (addr_ff),
      .rdata (q_rd)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_level_ff <= THR_RESET;
         coef_ff      <= COEF_RESET;
         look_ff      <= LOOK_RESET;
         wp_ff        <= '0;
         env_ff       <= UNITY;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_THRESHOLD_LEVEL:     thr_level_ff <= csr_data[THR_W-1:0];
               CSR_RELEASE_COEFFICIENT: coef_ff      <= csr_data[COEF_W-1:0];
               CSR_LOOKAHEAD_SAMPLES:   look_ff      <= csr_data[LOOK_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clear || cmd.accept) begin
            wp_ff <= wp_next;
         end
         if (cmd.gain_upd) begin
            if (target_ff < env_ff) begin
               env_ff <= target_ff;
            end else begin
               env_ff <= target_ff - prod_ff[GAIN_W+COEF_W-1:COEF_W];
            end
         end
         pend_ff <= ram_re;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         wcur_ff  <= wp_ff;
         thr_ff   <= thr_c;
         addr_ff  <= rd_c;
         left_ff  <= {1'b0, lsat} + 1'b1;
         first_ff <= 1'b1;
         peak_ff  <= '0;
      end
      if (ram_re) begin
         left_ff  <= left_ff - 1'b1;
         first_ff <= 1'b0;
         if (first_ff) begin
            addr_ff <= wcur_ff;
         end else if (addr_ff == '0) begin
            addr_ff <= LAST_ADDR;
         end else begin
            addr_ff <= addr_ff - 1'b1;
         end
      end
      pend_first_ff <= first_ff;
      if (pend_ff) begin
         if (pend_first_ff) begin
            delayed_ff <= $signed(q_rd);
         end else if (mag > peak_ff) begin
            peak_ff <= mag;
         end
      end
      if (cmd.div_init) begin
         rem_ff     <= {1'b0, thr_ff};
         quo_ff     <= '0;
         div_cnt_ff <= DIV_CNT_W'(DIV_STEPS);
         limited_ff <= peak_ff > thr_ff;
      end
      if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
         if (rem2 >= {1'b0, peak_ff}) begin
            rem_ff <= rem2 - {1'b0, peak_ff};
            quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_ff <= rem2;
            quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b0};
         end
      end
      if (cmd.gain_mul) begin
         target_ff <= target_c;
         prod_ff   <= diff_c * coef_ff;
      end
      if (cmd.out_mul) begin
         outp_ff <= delayed_ff * $signed({1'b0, env_ff});
      end
      if (cmd.finish) begin
         limited_out_ff <= sat_c;
         gain_now_ff    <= env_ff;
      end
   end

   assign status.clear_done = (wp_ff == LAST_ADDR);
   assign status.scan_done  = (left_ff == '0) && !pend_ff;
   assign status.limited    = limited_ff;
   assign status.div_done   = (div_cnt_ff == '0);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign limited_out = limited_out_ff;
   assign gain_now    = gain_now_ff;

`ifndef ASSERT_OFF
   a_peak_rises: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !pend_first_ff |=> peak_ff >= $past(peak_ff))
      else $error("window peak fell during scan");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> div_cnt_ff != '0)
      else $error("divider stepped past its last bit");
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> gain_now_ff <= UNITY)
      else $error("gain envelope above unity");
`endif

endmodule

// ===== rtl/lookahead_peak_limiter.sv =====
// ----------------------------------------------------------------------------
// lookahead_peak_limiter
// Look-ahead peak limiter on a fixed-point audio stream.
// ----------------------------------------------------------------------------
// One item at a time: a sample is taken only in idle, and one result follows
// each sample. The time an item takes depends on L, the lookahead length
// saturated to 1..DELAY_DEPTH, and on whether the window peak is above the
// threshold; it is set by the delay-line RAM, whose single read port scans
// the window one entry a cycle, and by the 15-step restoring divider, which
// runs only when the peak is above the threshold. The result sits in an
// output register, so the next sample is taken while it waits. After reset
// a clearing pass zeroes the delay line before the first sample; register
// writes are taken at any time and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter
   import lpl_pkg::*;
#(
   parameter int DELAY_DEPTH = 1024
) (
   input  logic      clock,
   input  logic      reset,
   lpl_req_if.sink   req_ch,
   lpl_rsp_if.source rsp_ch,
   lpl_csr_if.sink   csr_ch
);

   lpl_cmd_type    cmd;
   lpl_status_type status;

   assign csr_ch.ready = 1'b1;

   lpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpl_dp #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .audio_in     (req_ch.audio_in),
      .threshold_cv (req_ch.threshold_cv),
      .csr_write    (csr_ch.valid && csr_ch.ready),
      .csr_index    (csr_ch.index),
      .csr_data     (csr_ch.data),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .limited_out  (rsp_ch.limited_out),
      .gain_now     (rsp_ch.gain_now)
   );

endmodule
